// ===== sv/sct_pkg.sv =====
package sct_pkg;

	// Default depth of one argument slot and of the slot table
	localparam int BufSizeDefault = 64;

	// Character codes the tokenizer reacts to
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChNl    = 8'h0A;
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChSemi  = 8'h3B;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChHash  = 8'h23;

endpackage

// ===== sv/shell_command_tokenizer.sv =====
// Shell line tokenizer: one character per transfer on the input channel, one result per
// character on the output channel. Each result may carry a write into an external token
// store (argument slot, position, byte; a zero byte terminates an argument), a
// command-complete flag with the argument count, and an overflow flag when a slot or
// position index saturates at BUF_SIZE-1. A character passes an input register and a
// result register on its way from transfer in to result out, and one character is taken
// every cycle while the output side keeps accepting; the only loop is the update of the
// quote, comment and position state.
module shell_command_tokenizer
	import sct_pkg::*;
#(
	parameter int BUF_SIZE = BufSizeDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       store_write,
	output logic [5:0] store_arg,
	output logic [5:0] store_pos,
	output logic [7:0] store_byte,
	output logic       command_done,
	output logic       count_valid,
	output logic [6:0] arg_count,
	output logic       overflow
);

	localparam int PW = (BUF_SIZE > 2) ? $clog2(BUF_SIZE) : 1;
	localparam logic [PW-1:0] PosLimit = PW'(BUF_SIZE - 1);

	// input stage
	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          eoi_s1;

	// tokenizer state
	logic          quoting_q, commenting_q, after_space_q;
	logic [PW-1:0] arg_pos_q, char_pos_q;

	// next state and result
	logic          quoting_d, commenting_d, after_space_d;
	logic [PW-1:0] arg_pos_d, char_pos_d;
	logic          wr_d, done_d, cval_d, ovf_d;
	logic [PW-1:0] wa_d, wp_d;
	logic [7:0]    wb_d;
	logic [7:0]    c;
	logic          nl, cmd_sep, arg_sep;
	logic [PW+5:0] wa_ext, wp_ext;
	logic [PW+7:0] cnt_ext;

	logic          out_valid_q;
	logic          advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		c             = eoi_s1 ? ChNl : char_s1;
		nl            = (c == ChNl);
		cmd_sep       = nl || (c == ChNul) || (c == ChSemi);
		arg_sep       = (c == ChSpace) || (c == ChTab);
		quoting_d     = quoting_q;
		commenting_d  = commenting_q;
		after_space_d = after_space_q;
		arg_pos_d     = arg_pos_q;
		char_pos_d    = char_pos_q;
		wr_d          = 1'b0;
		done_d        = 1'b0;
		cval_d        = 1'b0;
		ovf_d         = 1'b0;
		wa_d          = '0;
		wp_d          = '0;
		wb_d          = '0;
		if (commenting_q && !nl) begin
			// skip the rest of the comment
		end else if (c == ChQuote) begin
			quoting_d = !quoting_q;
		end else begin
			if (nl) begin
				commenting_d  = 1'b0;
				after_space_d = 1'b0;
			end
			if (cmd_sep && !quoting_q) begin
				if (!after_space_d) begin
					wr_d       = 1'b1;
					wa_d       = arg_pos_q;
					wp_d       = char_pos_q;
					cval_d     = 1'b1;
					arg_pos_d  = '0;
					char_pos_d = '0;
				end
				after_space_d = 1'b1;
				done_d        = 1'b1;
			end else if (arg_sep && !quoting_q) begin
				if (!after_space_d) begin
					wr_d       = 1'b1;
					wa_d       = arg_pos_q;
					wp_d       = char_pos_q;
					char_pos_d = '0;
					if (arg_pos_q >= PosLimit) begin
						ovf_d     = 1'b1;
						arg_pos_d = PosLimit;
					end else begin
						arg_pos_d = arg_pos_q + 1'b1;
					end
				end
				after_space_d = 1'b1;
			end else if (c == ChHash && !quoting_q) begin
				commenting_d = 1'b1;
			end else begin
				wr_d = 1'b1;
				wa_d = arg_pos_q;
				wp_d = char_pos_q;
				wb_d = c;
				if (char_pos_q >= PosLimit) begin
					ovf_d      = 1'b1;
					char_pos_d = PosLimit;
				end else begin
					char_pos_d = char_pos_q + 1'b1;
				end
				after_space_d = 1'b0;
			end
		end
		wa_ext  = (PW+6)'(wa_d);
		wp_ext  = (PW+6)'(wp_d);
		cnt_ext = cval_d ? ((PW+8)'(arg_pos_q) + (PW+8)'(1)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q     <= 1'b0;
			commenting_q  <= 1'b0;
			after_space_q <= 1'b0;
			arg_pos_q     <= '0;
			char_pos_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				quoting_q     <= quoting_d;
				commenting_q  <= commenting_d;
				after_space_q <= after_space_d;
				arg_pos_q     <= arg_pos_d;
				char_pos_q    <= char_pos_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// result register: hold while the output side stalls
	always_ff @(posedge clk) begin
		if (advance) begin
			store_write  <= wr_d;
			store_arg    <= wa_ext[5:0];
			store_pos    <= wp_ext[5:0];
			store_byte   <= wb_d;
			command_done <= done_d;
			count_valid  <= cval_d;
			arg_count    <= cnt_ext[6:0];
			overflow     <= ovf_d;
		end
	end

	assign out_valid = out_valid_q;

	a_count_ends_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_valid |-> command_done && store_write && store_byte == 8'h00)
		else $error("count given without a terminating write");

	a_overflow_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> store_write && !count_valid)
		else $error("overflow without a store write");

	a_stall_only_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while output free");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item produced no result");

endmodule
